### sv/clcd_pkg.sv
`timescale 1ns / 1ps

package clcd_pkg;

	// Screen geometry.
	localparam int ROWS       = 2;
	localparam int COLUMNS    = 16;
	localparam int ROW_STRIDE = 40;

	localparam int ROW_W  = 1;
	localparam int COL_W  = 5;
	localparam int ADDR_W = 7;
	localparam int CNT_W  = 6;

	// Job queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Controller command bytes.
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] CMD_DISP_CTRL    = 8'h08;
	localparam logic [7:0] CMD_DISP_ALL_ON  = 8'h0F;
	localparam logic [7:0] CMD_SHIFT        = 8'h10;
	localparam logic [7:0] CMD_FUNC_SET     = 8'h28;
	localparam logic [7:0] SHIFT_RIGHT_BIT  = 8'h04;
	localparam logic [7:0] DISP_ON_BITS     = 8'h07;
	localparam logic [7:0] DISP_BIT         = 8'h04;
	localparam logic [7:0] CURSOR_BITS      = 8'h03;
	localparam logic [7:0] NIB_WAKE         = 8'h03;
	localparam logic [7:0] NIB_FOUR_BIT     = 8'h02;

	localparam logic [CNT_W-1:0] INIT_LEN     = 6'd9;
	localparam logic [CNT_W-1:0] INIT_NIB_LEN = 6'd4;

	typedef enum logic [2:0] {
		FUNC_INIT    = 3'd0,
		FUNC_WR_CHAR = 3'd1,
		FUNC_SET_CUR = 3'd2,
		FUNC_CLEAR   = 3'd3,
		FUNC_DISPLAY = 3'd4,
		FUNC_CURSOR  = 3'd5
	} func_t;

	typedef enum logic {
		JOB_RUN  = 1'b0,
		JOB_INIT = 1'b1
	} job_kind_t;

	// One queued job: an optional leading write followed by a run of shifts,
	// or the fixed power-up sequence.
	typedef struct packed {
		job_kind_t         kind;
		logic              head_valid;
		logic              head_rs;
		logic [7:0]        head_value;
		logic              run_right;
		logic [CNT_W-1:0]  count;
		logic              disp;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic       nibble;
		logic [7:0] value;
	} init_word_t;

	function automatic init_word_t init_word(input logic [3:0] idx);
		init_word_t w;
		unique case (idx)
			4'd0:    w = '{nibble: 1'b1, value: NIB_WAKE};
			4'd1:    w = '{nibble: 1'b1, value: NIB_WAKE};
			4'd2:    w = '{nibble: 1'b1, value: NIB_WAKE};
			4'd3:    w = '{nibble: 1'b1, value: NIB_FOUR_BIT};
			4'd4:    w = '{nibble: 1'b0, value: CMD_FUNC_SET};
			4'd5:    w = '{nibble: 1'b0, value: CMD_DISP_CTRL};
			4'd6:    w = '{nibble: 1'b0, value: CMD_CLEAR};
			4'd7:    w = '{nibble: 1'b0, value: CMD_ENTRY_MODE};
			4'd8:    w = '{nibble: 1'b0, value: CMD_DISP_ALL_ON};
			default: w = '{nibble: 1'b0, value: 8'h00};
		endcase
		return w;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		return (row[0] ? ADDR_W'(ROW_STRIDE) : ADDR_W'(0)) + ADDR_W'(col);
	endfunction

endpackage

### sv/clcd_front.sv
`timescale 1ns / 1ps

module clcd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic [2:0]           func,
	input  logic [7:0]           char_code,
	input  logic signed [7:0]    target_row,
	input  logic signed [7:0]    target_column,
	input  logic                 flag,
	output logic                 push,
	output clcd_pkg::job_t       push_job
);
	import clcd_pkg::*;

	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic              disp_q, disp_d;

	logic [COL_W-1:0]  col_inc;
	logic              wrap;
	logic [ROW_W-1:0]  next_row;
	logic [ROW_W-1:0]  set_row;
	logic [COL_W-1:0]  set_col;
	logic [ROW_W-1:0]  dst_row;
	logic [COL_W-1:0]  dst_col;
	logic [COL_W-1:0]  src_col;
	logic [ADDR_W-1:0] src_addr;
	logic [ADDR_W-1:0] dst_addr;
	logic signed [7:0] diff;
	logic [7:0]        mag;
	logic [CNT_W-1:0]  run_len;
	logic              run_right;
	job_t              job;
	logic              has_job;

	assign col_inc  = col_q + COL_W'(1);
	assign wrap     = col_inc >= COL_W'(COLUMNS);
	assign next_row = (row_q == ROW_W'(ROWS - 1)) ? ROW_W'(0) : ROW_W'(1);

	assign set_row = target_row[7] ? ROW_W'(0) :
		(target_row[6:0] >= 7'(ROWS)) ? ROW_W'(ROWS - 1) : target_row[ROW_W-1:0];
	assign set_col = target_column[7] ? COL_W'(0) :
		(target_column[6:0] >= 7'(COLUMNS)) ? COL_W'(COLUMNS - 1) :
		target_column[COL_W-1:0];

	// A wrapping character moves from the column just past the end.
	assign src_col = (func == FUNC_WR_CHAR) ? col_inc : col_q;
	assign dst_row = (func == FUNC_WR_CHAR) ? next_row : set_row;
	assign dst_col = (func == FUNC_WR_CHAR) ? COL_W'(0) : set_col;

	assign src_addr  = addr_of(row_q, src_col);
	assign dst_addr  = addr_of(dst_row, dst_col);
	assign diff      = $signed({1'b0, dst_addr}) - $signed({1'b0, src_addr});
	assign mag       = diff[7] ? 8'(-diff) : 8'(diff);
	assign run_len   = mag[CNT_W-1:0];
	assign run_right = !diff[7] && (diff != 8'sd0);

	always_comb begin
		row_d   = row_q;
		col_d   = col_q;
		disp_d  = disp_q;
		has_job = 1'b1;
		job     = '{kind: JOB_RUN, head_valid: 1'b1, head_rs: 1'b0,
			head_value: CMD_CLEAR, run_right: run_right, count: CNT_W'(1),
			disp: disp_q};
		unique case (func)
			FUNC_INIT: begin
				job.kind = JOB_INIT;
				job.count = INIT_LEN;
				row_d = '0;
				col_d = '0;
			end
			FUNC_WR_CHAR: begin
				job.head_rs = 1'b1;
				job.head_value = char_code;
				if (wrap) begin
					job.count = run_len + CNT_W'(1);
					row_d = next_row;
					col_d = '0;
				end else begin
					col_d = col_inc;
				end
			end
			FUNC_SET_CUR: begin
				job.head_valid = 1'b0;
				job.count = run_len;
				has_job = (run_len != '0);
				row_d = set_row;
				col_d = set_col;
			end
			FUNC_CLEAR: begin
				row_d = '0;
				col_d = '0;
			end
			FUNC_DISPLAY: begin
				disp_d = flag;
				job.disp = flag;
				job.head_value = CMD_DISP_CTRL | (flag ? DISP_ON_BITS : 8'h00);
			end
			FUNC_CURSOR: begin
				job.head_value = CMD_DISP_CTRL | (disp_q ? DISP_BIT : 8'h00) |
					(flag ? CURSOR_BITS : 8'h00);
			end
			default: begin
				has_job = 1'b0;
			end
		endcase
	end

	assign push     = acc && has_job;
	assign push_job = job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			disp_q <= 1'b0;
		end else if (acc) begin
			row_q  <= row_d;
			col_q  <= col_d;
			disp_q <= disp_d;
		end
	end

endmodule

### sv/clcd_queue.sv
`timescale 1ns / 1ps

module clcd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  clcd_pkg::job_t       push_job,
	input  logic                 pop,
	output clcd_pkg::job_t       pop_job,
	output clcd_pkg::q_status_t  status
);
	import clcd_pkg::*;

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_job      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

### sv/clcd_back.sv
`timescale 1ns / 1ps

module clcd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  clcd_pkg::job_t       pop_job,
	input  clcd_pkg::q_status_t  q_status,
	output logic                 pop,
	output logic                 wr_valid,
	input  logic                 wr_stall,
	output logic                 rs,
	output logic [7:0]           value,
	output logic                 nibble_only,
	output logic                 display_on,
	output logic                 last
);
	import clcd_pkg::*;

	typedef enum logic [1:0] {
		BK_IDLE = 2'b01,
		BK_BUSY = 2'b10
	} bk_state_t;

	bk_state_t        state_q;
	job_t             job_q;
	logic [CNT_W-1:0] step_q;
	logic             valid_q;
	logic             rs_q;
	logic [7:0]       value_q;
	logic             nib_q;
	logic             disp_q;
	logic             last_q;

	logic             advance;
	logic             step_last;
	logic             step_rs;
	logic [7:0]       step_value;
	logic             step_nib;
	init_word_t       iw;

	assign advance   = !valid_q || !wr_stall;
	assign pop       = (state_q == BK_IDLE) && !q_status.empty;
	assign step_last = (step_q == job_q.count - CNT_W'(1));
	assign iw        = init_word(step_q[3:0]);

	always_comb begin
		step_rs    = 1'b0;
		step_nib   = 1'b0;
		step_value = CMD_SHIFT | (job_q.run_right ? SHIFT_RIGHT_BIT : 8'h00);
		if (job_q.kind == JOB_INIT) begin
			step_value = iw.value;
			step_nib   = iw.nibble;
		end else if (job_q.head_valid && (step_q == '0)) begin
			step_rs    = job_q.head_rs;
			step_value = job_q.head_value;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
		if ((state_q == BK_BUSY) && advance) begin
			rs_q    <= step_rs;
			value_q <= step_value;
			nib_q   <= step_nib;
			disp_q  <= job_q.disp;
			last_q  <= step_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (advance) begin
						valid_q <= 1'b0;
					end
					if (pop) begin
						state_q <= BK_BUSY;
						step_q  <= '0;
					end
				end
				BK_BUSY: begin
					if (advance) begin
						valid_q <= 1'b1;
						step_q  <= step_q + CNT_W'(1);
						if (step_last) begin
							state_q <= BK_IDLE;
						end
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	assign wr_valid    = valid_q;
	assign rs          = rs_q;
	assign value       = value_q;
	assign nibble_only = nib_q;
	assign display_on  = disp_q;
	assign last        = last_q;

endmodule

### sv/char_lcd_command_sequencer.sv
// Character LCD command sequencer: commands in, controller writes out.
// A command's first write passes the job queue, then the back end's job
// register and output registers. Throughput: one write per cycle from the
// back end when not stalled, one job at a time; two commands can wait queued.
// Reset (arst_n low, asynchronous): cursor at row 0, column 0, display off,
// queue empty, no write pending.
`timescale 1ns / 1ps

module char_lcd_command_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  logic [2:0]        func,
	input  logic [7:0]        char_code,
	input  logic signed [7:0] target_row,
	input  logic signed [7:0] target_column,
	input  logic              flag,
	output logic              wr_valid,
	input  logic              wr_stall,
	output logic              rs,
	output logic [7:0]        value,
	output logic              nibble_only,
	output logic              display_on,
	output logic              last
);
	import clcd_pkg::*;

	logic      acc;
	logic      q_push;
	logic      q_pop;
	job_t      push_job;
	job_t      pop_job;
	q_status_t q_status;

	assign cmd_stall = q_status.full;
	assign acc       = cmd_valid && !q_status.full;

	clcd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.func          (func),
		.char_code     (char_code),
		.target_row    (target_row),
		.target_column (target_column),
		.flag          (flag),
		.push          (q_push),
		.push_job      (push_job)
	);

	clcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.pop_job  (pop_job),
		.status   (q_status)
	);

	clcd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_job     (pop_job),
		.q_status    (q_status),
		.pop         (q_pop),
		.wr_valid    (wr_valid),
		.wr_stall    (wr_stall),
		.rs          (rs),
		.value       (value),
		.nibble_only (nibble_only),
		.display_on  (display_on),
		.last        (last)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_status.full)
		else $error("job pushed into a full queue");

	a_pop_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("job popped from an empty queue");

	a_nibble_is_command: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_valid && nibble_only) |-> (!rs && (value[7:4] == 4'h0)))
		else $error("nibble transfer with data select or upper bits set");
`endif

endmodule

### sim/tb_char_lcd_command_sequencer.sv
`timescale 1ns / 1ps

module tb_char_lcd_command_sequencer;
	import clcd_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_CMDS = 125;
	localparam int HOLD_AFTER = 40;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [2:0]        func;
		logic [7:0]        char_code;
		logic signed [7:0] target_row;
		logic signed [7:0] target_column;
		logic              flag;
	} lcd_cmd_t;

	typedef struct {
		logic       rs;
		logic [7:0] value;
		logic       nibble_only;
		logic       display_on;
		logic       last;
	} lcd_write_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cmd_valid = 1'b0;
	logic              cmd_stall;
	logic [2:0]        func = 3'd0;
	logic [7:0]        char_code = 8'd0;
	logic signed [7:0] target_row = 8'sd0;
	logic signed [7:0] target_column = 8'sd0;
	logic              flag = 1'b0;
	logic              wr_valid;
	logic              wr_stall = 1'b0;
	logic              rs;
	logic [7:0]        value;
	logic              nibble_only;
	logic              display_on;
	logic              last;

	lcd_cmd_t   lcd_cmds_pending[$];
	lcd_write_t lcd_writes_due[$];

	// Shadow of the cursor and display state.
	logic       cur_row = 1'b0;
	logic [4:0] cur_col = 5'd0;
	logic       cur_disp = 1'b0;

	// The newest write of a command is held back so that it can be marked last.
	lcd_write_t held_write;
	bit         held_valid = 1'b0;

	int cmds_accepted = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int run_left = 0;
	int hold_left = 0;
	logic hold_off = 1'b0;
	logic hold_done = 1'b0;

	char_lcd_command_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.func         (func),
		.char_code    (char_code),
		.target_row   (target_row),
		.target_column(target_column),
		.flag         (flag),
		.wr_valid     (wr_valid),
		.wr_stall     (wr_stall),
		.rs           (rs),
		.value        (value),
		.nibble_only  (nibble_only),
		.display_on   (display_on),
		.last         (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < 30)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic add_cmd(input logic [2:0] f, input int ch, input int row, input int col,
			input int fl);
		lcd_cmd_t c;
		c.func = f;
		c.char_code = ch[7:0];
		c.target_row = row[7:0];
		c.target_column = col[7:0];
		c.flag = fl[0];
		lcd_cmds_pending.push_back(c);
	endtask

	task automatic queue_write(input logic w_rs, input logic [7:0] w_value, input logic w_nib);
		lcd_write_t w;
		w.rs = w_rs;
		w.value = w_value;
		w.nibble_only = w_nib;
		w.display_on = cur_disp;
		w.last = 1'b0;
		if (held_valid)
			lcd_writes_due.push_back(held_write);
		held_write = w;
		held_valid = 1'b1;
	endtask

	task automatic shift_cursor_to(input int row, input int col);
		int span;
		logic [7:0] code;
		span = (row * ROW_STRIDE + col) - (int'(cur_row) * ROW_STRIDE + int'(cur_col));
		code = CMD_SHIFT;
		if (span > 0)
			code = code | SHIFT_RIGHT_BIT;
		else
			span = -span;
		for (int i = 0; i < span; i++)
			queue_write(1'b0, code, 1'b0);
		cur_row = row[0];
		cur_col = col[4:0];
	endtask

	task automatic predict_lcd_writes(input lcd_cmd_t c);
		int row;
		int col;
		row = c.target_row;
		col = c.target_column;
		case (c.func)
			FUNC_INIT: begin
				cur_row = 1'b0;
				cur_col = 5'd0;
				queue_write(1'b0, NIB_WAKE, 1'b1);
				queue_write(1'b0, NIB_WAKE, 1'b1);
				queue_write(1'b0, NIB_WAKE, 1'b1);
				queue_write(1'b0, NIB_FOUR_BIT, 1'b1);
				queue_write(1'b0, CMD_FUNC_SET, 1'b0);
				queue_write(1'b0, CMD_DISP_CTRL, 1'b0);
				queue_write(1'b0, CMD_CLEAR, 1'b0);
				queue_write(1'b0, CMD_ENTRY_MODE, 1'b0);
				queue_write(1'b0, CMD_DISP_ALL_ON, 1'b0);
			end
			FUNC_WR_CHAR: begin
				queue_write(1'b1, c.char_code, 1'b0);
				cur_col = cur_col + 5'd1;
				if (int'(cur_col) >= COLUMNS)
					shift_cursor_to((int'(cur_row) == ROWS - 1) ? 0 : 1, 0);
			end
			FUNC_SET_CUR: begin
				if (row < 0) row = 0;
				else if (row >= ROWS) row = ROWS - 1;
				if (col < 0) col = 0;
				else if (col >= COLUMNS) col = COLUMNS - 1;
				shift_cursor_to(row, col);
			end
			FUNC_CLEAR: begin
				queue_write(1'b0, CMD_CLEAR, 1'b0);
				cur_row = 1'b0;
				cur_col = 5'd0;
			end
			FUNC_DISPLAY: begin
				cur_disp = c.flag;
				queue_write(1'b0, CMD_DISP_CTRL | (c.flag ? DISP_ON_BITS : 8'h00), 1'b0);
			end
			FUNC_CURSOR: begin
				queue_write(1'b0, CMD_DISP_CTRL | (cur_disp ? DISP_BIT : 8'h00)
					| (c.flag ? CURSOR_BITS : 8'h00), 1'b0);
			end
			default: begin
			end
		endcase
		if (held_valid) begin
			held_write.last = 1'b1;
			lcd_writes_due.push_back(held_write);
			held_valid = 1'b0;
		end
	endtask

	// Command driver: bursts of items separated by random gaps.
	always @(posedge clk) begin : cmd_driver
		logic nxt_valid;
		if (arst_n) begin
			nxt_valid = cmd_valid;
			if (cmd_valid && !cmd_stall) begin
				predict_lcd_writes(lcd_cmds_pending[0]);
				void'(lcd_cmds_pending.pop_front());
				cmds_accepted <= cmds_accepted + 1;
				nxt_valid = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25)
						: $urandom_range(0, 4);
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (lcd_cmds_pending.size() > 0) begin
					nxt_valid = 1'b1;
					func <= lcd_cmds_pending[0].func;
					char_code <= lcd_cmds_pending[0].char_code;
					target_row <= lcd_cmds_pending[0].target_row;
					target_column <= lcd_cmds_pending[0].target_column;
					flag <= lcd_cmds_pending[0].flag;
					if (burst_left == 0)
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
							: $urandom_range(1, 10);
				end
			end
			cmd_valid <= nxt_valid;
		end
	end

	// Write monitor and receiver stall pattern.
	always @(posedge clk) begin : wr_monitor
		lcd_write_t exp_w;
		logic nxt_stall;
		if (arst_n) begin
			if (wr_valid && !wr_stall) begin
				if (lcd_writes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected write rs=%0b value=%02h nib=%0b",
						rs, value, nibble_only));
				end else begin
					exp_w = lcd_writes_due.pop_front();
					if (rs !== exp_w.rs || value !== exp_w.value
							|| nibble_only !== exp_w.nibble_only
							|| display_on !== exp_w.display_on || last !== exp_w.last)
						report_mismatch($sformatf(
							"got rs=%0b value=%02h nib=%0b disp=%0b last=%0b, want %0b %02h %0b %0b %0b",
							rs, value, nibble_only, display_on, last, exp_w.rs, exp_w.value,
							exp_w.nibble_only, exp_w.display_on, exp_w.last));
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(30, 150);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: nxt_stall = 1'b0;
				1: nxt_stall = ($urandom_range(0, 1) == 1);
				2: nxt_stall = (mode_left % 3 == 0);
				default: begin
					if (run_left > 0) begin
						nxt_stall = 1'b1;
						run_left--;
					end else begin
						nxt_stall = 1'b0;
						if ($urandom_range(0, 15) == 0)
							run_left = $urandom_range(2, 12);
					end
				end
			endcase
			wr_stall <= nxt_stall | hold_off;
		end
	end

	// One long hold-off on the write side so that the job queue fills.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				if (hold_left == 1)
					hold_off <= 1'b0;
			end else if (!hold_done && cmds_accepted >= HOLD_AFTER) begin
				hold_off <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (wr_valid && !wr_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no item accepted for %0d cycles", IDLE_LIMIT);
				$display("** char_lcd_command_sequencer: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int n;
		int pick;
		int run;
		n = 0;
		// Directed part: every command, field extremes, both wrap cases and
		// cursor moves of zero distance.
		add_cmd(FUNC_INIT, 8'h00, 0, 0, 0);
		add_cmd(FUNC_DISPLAY, 8'hFF, 0, 0, 1);
		add_cmd(FUNC_CURSOR, 8'h00, 0, 0, 1);
		add_cmd(FUNC_CURSOR, 8'h00, 0, 0, 0);
		add_cmd(FUNC_DISPLAY, 8'h00, 0, 0, 0);
		add_cmd(FUNC_CURSOR, 8'h00, 0, 0, 1);
		add_cmd(FUNC_WR_CHAR, 8'h00, 0, 0, 0);
		add_cmd(FUNC_WR_CHAR, 8'hFF, -1, -1, 1);
		add_cmd(FUNC_SET_CUR, 8'h00, 127, 127, 0);
		add_cmd(FUNC_WR_CHAR, 8'hA5, 0, 0, 0);
		add_cmd(FUNC_SET_CUR, 8'h00, -128, -128, 0);
		add_cmd(FUNC_SET_CUR, 8'h00, 0, COLUMNS - 1, 0);
		add_cmd(FUNC_WR_CHAR, 8'h5A, 0, 0, 0);
		add_cmd(FUNC_SET_CUR, 8'h00, 1, 0, 0);
		add_cmd(FUNC_SET_CUR, 8'h00, 0, 0, 0);
		add_cmd(3'd6, 8'hFF, 127, -128, 1);
		add_cmd(3'd7, 8'h00, -128, 127, 0);
		add_cmd(FUNC_SET_CUR, 8'h00, 1, 7, 0);
		add_cmd(FUNC_CLEAR, 8'hFF, -1, -1, 1);
		add_cmd(FUNC_SET_CUR, 8'h00, ROWS, COLUMNS, 0);
		add_cmd(FUNC_SET_CUR, 8'h00, -1, -1, 0);
		add_cmd(FUNC_SET_CUR, 8'h00, 1, 3, 0);
		add_cmd(FUNC_INIT, 8'hFF, -1, -1, 1);
		add_cmd(FUNC_DISPLAY, 8'h00, 0, 0, 1);
		add_cmd(FUNC_CURSOR, 8'h00, 0, 0, 0);
		// Random part: mostly runs of characters and cursor moves near the edges.
		while (n < RANDOM_CMDS) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				add_cmd(3'($urandom_range(6, 7)), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1));
			end else if (pick < 45) begin
				run = $urandom_range(1, 20);
				for (int i = 0; i < run; i++)
					add_cmd(FUNC_WR_CHAR, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 1));
				n += run;
			end else begin
				if (pick < 70) begin
					if ($urandom_range(0, 3) != 0)
						add_cmd(FUNC_SET_CUR, $urandom_range(0, 255),
							int'($urandom_range(0, 3)) - 1,
							int'($urandom_range(0, COLUMNS + 2)) - 1, $urandom_range(0, 1));
					else
						add_cmd(FUNC_SET_CUR, $urandom_range(0, 255), $urandom_range(0, 255),
							$urandom_range(0, 255), $urandom_range(0, 1));
				end else if (pick < 78) begin
					add_cmd(FUNC_DISPLAY, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 1));
				end else if (pick < 86) begin
					add_cmd(FUNC_CURSOR, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 1));
				end else if (pick < 93) begin
					add_cmd(FUNC_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 1));
				end else begin
					add_cmd(FUNC_INIT, $urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 1));
				end
				n++;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (lcd_cmds_pending.size() != 0 || cmd_valid)
			@(posedge clk);
		while (lcd_writes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("** char_lcd_command_sequencer: PASSED **");
		else
			$display("** char_lcd_command_sequencer: FAILED **");
		$finish;
	end

endmodule

### files.f
sv/clcd_pkg.sv
sv/clcd_front.sv
sv/clcd_queue.sv
sv/clcd_back.sv
sv/char_lcd_command_sequencer.sv
sim/tb_char_lcd_command_sequencer.sv
